FILE: rtl/cmjd_pkg.sv
// Shared constants, command codes and status codes of the job dispatcher.
package cmjd_pkg;

    // Worker key width and job table geometry.
    localparam int KEY_W = 8;
    localparam int JOB_W = 6;
    localparam int JOBS  = 1 << JOB_W;

    // Command codes carried by a request word.
    typedef enum logic [1:0] {
        CMD_ADD      = 2'd0,
        CMD_ASSIGN   = 2'd1,
        CMD_COMPLETE = 2'd2,
        CMD_NONE     = 2'd3
    } t_cmd;

    // Status codes carried by a result word.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOMATCH = 2'd1,
        ST_FULL    = 2'd2,
        ST_UNKNOWN = 2'd3
    } t_status;

endpackage

FILE: rtl/capability_matched_job_dispatcher.sv
// Capability-matched job dispatcher: worker table, job table and scan sequencer.
//
// One request word is handled at a time. An add, an unused command, a complete
// for a job that is not open and an assign on an empty table go straight to the
// result state; a complete reads the owner entry and then updates it, and an
// assign scans every filled entry and then updates the chosen worker. The assign
// time is set by the worker table, which has a single registered read port and
// is scanned one entry per cycle through one shared comparator. A finished
// result waits in the output register, so the next request word can be
// accepted while the previous result is still stalled.
module capability_matched_job_dispatcher import cmjd_pkg::*; #(
    parameter int WORKERS    = 16,
    parameter int CAP_BITS   = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_cmd,
    input  logic [KEY_W-1:0]    i_worker_key,
    input  logic [CAP_BITS-1:0] i_cap_mask,
    input  logic                i_criteria,
    input  logic [JOB_W-1:0]    i_job_num,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [KEY_W-1:0]    o_chosen_key,
    output logic [1:0]          o_status
);

    localparam int IDX_W  = (WORKERS > 1) ? $clog2(WORKERS) : 1;
    localparam int FILL_W = $clog2(WORKERS + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [KEY_W-1:0]      key;
        logic [CAP_BITS-1:0]   caps;
        logic [COUNT_BITS-1:0] open_cnt;
        logic [COUNT_BITS-1:0] done_cnt;
    } t_worker;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_AUPD,
        S_CRD,
        S_CUPD,
        S_RESP
    } t_state;

    t_state                r_state;
    logic [FILL_W-1:0]     r_fill;
    logic [JOBS-1:0]       r_job_valid;
    logic [CAP_BITS-1:0]   r_req;
    logic                  r_crit;
    logic [JOB_W-1:0]      r_job;
    logic [IDX_W-1:0]      r_idx;
    logic                  r_issue_done;
    logic                  r_rd_vld;
    logic [IDX_W-1:0]      r_rd_idx;
    logic                  r_found;
    t_worker               r_best;
    logic [IDX_W-1:0]      r_best_idx;
    logic [KEY_W-1:0]      r_res_key;
    t_status               r_res_status;
    logic                  r_out_valid;
    logic [KEY_W-1:0]      r_out_key;
    t_status               r_out_status;

    t_worker               r_wmem [WORKERS];
    t_worker               r_rd_data;
    logic [IDX_W-1:0]      r_jmem [JOBS];
    logic [IDX_W-1:0]      r_owner;

    logic                  w_accept;
    t_cmd                  w_cmd;
    logic                  w_full;
    logic [FILL_W-1:0]     w_last;
    logic [IDX_W-1:0]      w_rd_addr;
    logic                  w_take;
    logic                  w_we;
    logic [IDX_W-1:0]      w_waddr;
    t_worker               w_wdata;

    // Handshake and decode.
    assign w_accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall   = (r_state != S_IDLE);
    assign w_cmd        = t_cmd'(i_cmd);
    assign w_full       = (r_fill == FILL_W'(WORKERS));
    assign w_last       = r_fill - FILL_W'(1);
    assign o_out_valid  = r_out_valid;
    assign o_chosen_key = r_out_key;
    assign o_status     = r_out_status;

    // The read port serves the scan, or the owner lookup of a complete.
    assign w_rd_addr = (r_state == S_CRD) ? r_owner : r_idx;

    // Shared comparator over the entry just read and the best so far.
    cmjd_cmp #(
        .CAP_BITS   (CAP_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_cmp (
        .i_criteria  (r_crit),
        .i_req       (r_req),
        .i_have_best (r_found),
        .i_cand_caps (r_rd_data.caps),
        .i_cand_key  (r_rd_data.key),
        .i_cand_open (r_rd_data.open_cnt),
        .i_cand_done (r_rd_data.done_cnt),
        .i_best_key  (r_best.key),
        .i_best_open (r_best.open_cnt),
        .i_best_done (r_best.done_cnt),
        .o_take      (w_take)
    );

    // Worker table write port: new worker, assign update or complete update.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_fill[IDX_W-1:0];
        w_wdata = '{key: i_worker_key, caps: i_cap_mask, open_cnt: '0, done_cnt: '0};
        unique case (r_state)
            S_IDLE: begin
                w_we = w_accept && (w_cmd == CMD_ADD) && !w_full;
            end
            S_AUPD: begin
                w_we    = r_found;
                w_waddr = r_best_idx;
                w_wdata = r_best;
                if (r_best.open_cnt != COUNT_MAX) begin
                    w_wdata.open_cnt = r_best.open_cnt + COUNT_BITS'(1);
                end
            end
            S_CUPD: begin
                w_we    = 1'b1;
                w_waddr = r_owner;
                w_wdata = r_rd_data;
                if (r_rd_data.open_cnt != '0) begin
                    w_wdata.open_cnt = r_rd_data.open_cnt - COUNT_BITS'(1);
                end
                if (r_rd_data.done_cnt != COUNT_MAX) begin
                    w_wdata.done_cnt = r_rd_data.done_cnt + COUNT_BITS'(1);
                end
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // Worker table storage with a registered read.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_wmem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_wmem[w_rd_addr];
    end

    // Job owner storage; the owner is looked up as a word is accepted.
    always_ff @(posedge i_clk) begin
        if (r_state == S_AUPD && r_found) begin
            r_jmem[r_job] <= r_best_idx;
        end
        if (r_state == S_IDLE) begin
            r_owner <= r_jmem[i_job_num];
        end
    end

    // Sequencer, scan registers and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fill       <= '0;
            r_job_valid  <= '0;
            r_issue_done <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_found      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // The result state reloads the output register itself.
            if (r_out_valid && !i_out_stall && (r_state != S_RESP)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_req  <= i_cap_mask;
                        r_crit <= i_criteria;
                        r_job  <= i_job_num;
                        unique case (w_cmd)
                            CMD_ADD: begin
                                r_state <= S_RESP;
                                if (w_full) begin
                                    r_res_key    <= '0;
                                    r_res_status <= ST_FULL;
                                end else begin
                                    r_fill       <= r_fill + FILL_W'(1);
                                    r_res_key    <= i_worker_key;
                                    r_res_status <= ST_OK;
                                end
                            end
                            CMD_ASSIGN: begin
                                r_res_key <= '0;
                                if (r_fill == '0) begin
                                    r_res_status <= ST_NOMATCH;
                                    r_state      <= S_RESP;
                                end else begin
                                    r_res_status <= ST_OK;
                                    r_state      <= S_SCAN;
                                    r_idx        <= '0;
                                    r_issue_done <= 1'b0;
                                    r_rd_vld     <= 1'b0;
                                    r_found      <= 1'b0;
                                end
                            end
                            CMD_COMPLETE: begin
                                if (!r_job_valid[i_job_num]) begin
                                    r_res_key    <= '0;
                                    r_res_status <= ST_UNKNOWN;
                                    r_state      <= S_RESP;
                                end else begin
                                    r_res_status <= ST_OK;
                                    r_state      <= S_CRD;
                                end
                            end
                            CMD_NONE: begin
                                r_res_key    <= '0;
                                r_res_status <= ST_OK;
                                r_state      <= S_RESP;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    // Issue one read per cycle and compare the entry read before.
                    r_rd_vld <= !r_issue_done;
                    r_rd_idx <= r_idx;
                    if (!r_issue_done) begin
                        if (r_idx == w_last[IDX_W-1:0]) begin
                            r_issue_done <= 1'b1;
                        end else begin
                            r_idx <= r_idx + IDX_W'(1);
                        end
                    end
                    if (r_rd_vld && w_take) begin
                        r_found    <= 1'b1;
                        r_best     <= r_rd_data;
                        r_best_idx <= r_rd_idx;
                    end
                    if (r_rd_vld && r_issue_done) begin
                        r_state <= S_AUPD;
                    end
                end
                S_AUPD: begin
                    if (r_found) begin
                        r_job_valid[r_job] <= 1'b1;
                        r_res_key          <= r_best.key;
                    end else begin
                        r_res_status <= ST_NOMATCH;
                    end
                    r_state <= S_RESP;
                end
                S_CRD: begin
                    r_state <= S_CUPD;
                end
                S_CUPD: begin
                    r_job_valid[r_job] <= 1'b0;
                    r_res_key          <= r_rd_data.key;
                    r_state            <= S_RESP;
                end
                S_RESP: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid  <= 1'b1;
                        r_out_key    <= r_res_key;
                        r_out_status <= r_res_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // The worker count never passes the table size.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(WORKERS))
        else $error("worker count exceeds table size");

    // An accepted word always starts work.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("accepted word left the sequencer idle");

    // The scan only reads filled entries.
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (FILL_W'(r_idx) < r_fill))
        else $error("scan index beyond filled entries");

    // A chosen worker is always a filled entry.
    a_best_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AUPD && r_found) |-> (FILL_W'(r_best_idx) < r_fill))
        else $error("chosen worker beyond filled entries");

    // A result leaves the sequencer once the output register is free.
    a_resp_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && (!r_out_valid || !i_out_stall))
        |=> (o_out_valid && r_state == S_IDLE))
        else $error("result not loaded into output register");

endmodule

FILE: rtl/cmjd_cmp.sv
// Shared compare unit: decides whether a scanned worker replaces the best so far.
module cmjd_cmp import cmjd_pkg::*; #(
    parameter int CAP_BITS   = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                  i_criteria,
    input  logic [CAP_BITS-1:0]   i_req,
    input  logic                  i_have_best,
    input  logic [CAP_BITS-1:0]   i_cand_caps,
    input  logic [KEY_W-1:0]      i_cand_key,
    input  logic [COUNT_BITS-1:0] i_cand_open,
    input  logic [COUNT_BITS-1:0] i_cand_done,
    input  logic [KEY_W-1:0]      i_best_key,
    input  logic [COUNT_BITS-1:0] i_best_open,
    input  logic [COUNT_BITS-1:0] i_best_done,
    output logic                  o_take
);

    logic w_eligible;
    logic w_better;

    // The worker must offer every required capability.
    assign w_eligible = (i_cand_caps & i_req) == i_req;

    // Rank by load or by finished work; equal counts fall back to the smaller key.
    always_comb begin
        if (!i_criteria) begin
            if (i_cand_open != i_best_open) begin
                w_better = i_cand_open < i_best_open;
            end else begin
                w_better = i_cand_key < i_best_key;
            end
        end else begin
            if (i_cand_done != i_best_done) begin
                w_better = i_cand_done > i_best_done;
            end else begin
                w_better = i_cand_key < i_best_key;
            end
        end
    end

    assign o_take = w_eligible && (!i_have_best || w_better);

endmodule
